>>> rtl/core/box_non_max_suppression_defines.svh
// Assertion macros for the box suppression block.
`ifndef BOX_NON_MAX_SUPPRESSION_DEFINES_SVH
`define BOX_NON_MAX_SUPPRESSION_DEFINES_SVH
`ifndef SYNTHESIS
`define BNMS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BNMS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BNMS_ASSERT(label, clk, rst_n, prop, msg)
`define BNMS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/core/bnms_pkg.sv
// Shared constants and types for the box suppression block.
package bnms_pkg;
  localparam int unsigned MaxBoxesDef = 64;
  localparam int unsigned PixelOne    = 16;
  localparam logic [15:0] IouReset    = 16'd32768;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
  } corners_t;

  // pair test request/response between the top level and the overlap unit
  typedef struct packed {
    logic     start;
    corners_t a;
    corners_t b;
  } iou_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } iou_rsp_t;
endpackage

>>> rtl/core/bnms_iou.sv
// Pipelined overlap test of two boxes against the threshold.
module bnms_iou
  import bnms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] thr_i,
  input  iou_req_t    req_i,
  output iou_rsp_t    rsp_o
);
  // extent = max(0, hi - lo + 16), at most 65551: 17 bits
  function automatic logic [16:0] ext(input logic [15:0] lo, input logic [15:0] hi);
    logic [17:0] d;
    d = {2'b0, hi} + 18'(PixelOne) - {2'b0, lo};
    return d[17] ? 17'd0 : d[16:0];
  endfunction

  logic [16:0] aw_q, ah_q, bw_q, bh_q, iw_q, ih_q;
  logic [33:0] area_a_q, area_b_q, inter_q, inter2_q;
  logic [34:0] uni_q;
  logic [50:0] lhs_q, rhs_q;
  logic [4:0]  vld_q;
  logic        hit_q;

  // stage 1: extents
  always_ff @(posedge clk_i) begin
    aw_q <= ext(req_i.a.left, req_i.a.right);
    ah_q <= ext(req_i.a.top, req_i.a.bottom);
    bw_q <= ext(req_i.b.left, req_i.b.right);
    bh_q <= ext(req_i.b.top, req_i.b.bottom);
    iw_q <= ext((req_i.a.left > req_i.b.left) ? req_i.a.left : req_i.b.left,
                (req_i.a.right < req_i.b.right) ? req_i.a.right : req_i.b.right);
    ih_q <= ext((req_i.a.top > req_i.b.top) ? req_i.a.top : req_i.b.top,
                (req_i.a.bottom < req_i.b.bottom) ? req_i.a.bottom : req_i.b.bottom);
  end

  // stage 2: areas, stage 3: union, stage 4: cross products, stage 5: compare
  always_ff @(posedge clk_i) begin
    area_a_q <= aw_q * ah_q;
    area_b_q <= bw_q * bh_q;
    inter_q  <= iw_q * ih_q;
    uni_q    <= {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};
    inter2_q <= inter_q;
    lhs_q    <= {1'b0, inter2_q, 16'd0};
    rhs_q    <= (uni_q == '0) ? '1 : (51'(thr_i) * 51'(uni_q));
    hit_q    <= (rhs_q != '1) && (lhs_q >= rhs_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], req_i.start};
    end
  end

  assign rsp_o.done = vld_q[4];
  assign rsp_o.hit  = hit_q;
endmodule

>>> rtl/core/box_non_max_suppression.sv
// Top level: sorted box store, greedy suppression sequencer, result output.
//  channel | valid      | stall      | payload
//  in      | in_valid_i | in_stall_o | box_class_i .. last_box_i
//  out     | out_valid_o| out_stall_i| kept_class_o .. overflowed_o
//  cfg     | cfg_we_i   | -          | cfg_data_i (iou_threshold)
// Loading a box walks the store with one memory read a cycle to insert it in
// order, appending it or first moving lower-scored entries up. The pass tests
// one pair at a time through the shared overlap pipeline, O(N^2/2) pairs; the
// output shows each survivor and skips dropped boxes. Reset clears counts and
// suppression bits; the stores are not reset.
// A stall on the output holds the sequencer; the input is stalled while busy.
`include "box_non_max_suppression_defines.svh"
module box_non_max_suppression
  import bnms_pkg::*;
#(
  parameter int unsigned MAX_BOXES = MaxBoxesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  box_class_i,
  input  logic [15:0] confidence_i,
  input  logic [15:0] left_i,
  input  logic [15:0] top_i,
  input  logic [15:0] right_i,
  input  logic [15:0] bottom_i,
  input  logic        last_box_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  kept_class_o,
  output logic [15:0] kept_confidence_o,
  output logic [15:0] kept_left_o,
  output logic [15:0] kept_top_o,
  output logic [15:0] kept_right_o,
  output logic [15:0] kept_bottom_o,
  output logic        last_result_o,
  output logic        overflowed_o
);
  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_WRITE, S_PI, S_PJ, S_PWAIT,
    S_ORD, S_OWAIT, S_OSHOW, S_DONE
  } state_e;

  // one entry: class, score, corners
  typedef struct packed {
    logic [7:0]  cls;
    logic [15:0] score;
    corners_t    c;
  } entry_t;

  entry_t mem_q [MAX_BOXES];
  entry_t rd_q;
  logic   rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  state_e        state_q;
  logic [CW-1:0] cnt_q, pos_q, k_q, i_q, j_q;
  logic          ovf_q, last_q, rd_pend_q, rd_pend_d;
  logic [15:0]   thr_q;
  entry_t        new_q;
  corners_t      ci_q;
  logic [MAX_BOXES-1:0] sup_q;
  logic [CW-1:0] last_keep_q, last_keep_d;
  iou_req_t      req;
  iou_rsp_t      rsp;

  bnms_iou u_iou (
    .clk_i (clk_i), .rst_ni(rst_ni), .thr_i(thr_q), .req_i(req), .rsp_o(rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  wire in_acc = in_valid_i && !in_stall_o;

  // memory port control
  always_comb begin
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = new_q;
    req.start = 1'b0; req.a = ci_q; req.b = rd_q.c;
    case (state_q)
      // read ahead by one once the first entry is in flight
      S_SCAN:  begin rd_en = 1'b1; rd_addr = AW'(pos_q + CW'(rd_pend_q)); end
      S_SHIFT: begin
        // first cycle reads k-1; then move entry k-1 up to k and read k-2
        wr_en = rd_pend_q; wr_addr = k_q[AW-1:0]; wr_data = rd_q;
        rd_en = 1'b1;
        rd_addr = rd_pend_q ? AW'(k_q - CW'(2)) : AW'(k_q - CW'(1));
      end
      S_WRITE: begin wr_en = 1'b1; wr_addr = pos_q[AW-1:0]; wr_data = new_q; end
      S_PI:    begin rd_en = 1'b1; rd_addr = i_q[AW-1:0]; end
      S_PJ:    begin rd_en = 1'b1; rd_addr = j_q[AW-1:0]; end
      S_PWAIT: req.start = rd_pend_q;
      S_ORD:   begin rd_en = 1'b1; rd_addr = i_q[AW-1:0]; end
      default: ;
    endcase
    // a scan that stops hands over to the shift with no read in flight
    rd_pend_d = rd_en;
    if (state_q == S_SCAN && rd_pend_q && (rd_q.score < new_q.score)) rd_pend_d = 1'b0;
  end

  // last survivor in store order
  always_comb begin
    last_keep_d = '0;
    for (int n = 0; n < MAX_BOXES; n++)
      if (!sup_q[n] && CW'(n) < cnt_q) last_keep_d = CW'(n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; ovf_q <= 1'b0; last_q <= 1'b0;
      thr_q <= IouReset; sup_q <= '0; rd_pend_q <= 1'b0;
      pos_q <= '0; k_q <= '0; i_q <= '0; j_q <= '0; last_keep_q <= '0;
      new_q <= '0; ci_q <= '0;
      kept_class_o <= '0; kept_confidence_o <= '0;
      kept_left_o <= '0; kept_top_o <= '0; kept_right_o <= '0; kept_bottom_o <= '0;
      last_result_o <= 1'b0; overflowed_o <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      rd_pend_q <= rd_pend_d;
      case (state_q)
        S_IDLE: if (in_acc) begin
          new_q  <= '{cls: box_class_i, score: confidence_i,
                     c: '{left: left_i, top: top_i, right: right_i, bottom: bottom_i}};
          last_q <= last_box_i;
          pos_q  <= '0;
          if (cnt_q == CW'(MAX_BOXES)) begin
            ovf_q <= 1'b1;
            if (last_box_i) begin i_q <= '0; j_q <= CW'(1); state_q <= S_PI; end
          end else if (cnt_q == '0) begin
            state_q <= S_WRITE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        // find first entry with score below the new one
        S_SCAN: if (rd_pend_q) begin
          if (rd_q.score >= new_q.score) begin
            if (pos_q + CW'(1) == cnt_q) begin
              pos_q <= cnt_q; state_q <= S_WRITE;
            end else pos_q <= pos_q + CW'(1);
          end else begin
            k_q <= cnt_q; state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (!rd_pend_q) begin
            // first cycle only issues the read of k-1
            k_q <= k_q;
          end else if (k_q == pos_q + CW'(1)) begin
            state_q <= S_WRITE;
          end else k_q <= k_q - CW'(1);
        end
        S_WRITE: begin
          cnt_q <= cnt_q + CW'(1);
          if (last_q) begin i_q <= '0; j_q <= CW'(1); state_q <= S_PI; end
          else state_q <= S_IDLE;
        end
        // greedy pass: read box i, then each j>i
        S_PI: begin
          if (i_q + CW'(1) >= cnt_q) begin
            i_q <= '0; state_q <= S_ORD;
          end else if (sup_q[i_q[AW-1:0]]) begin
            i_q <= i_q + CW'(1);
          end else begin
            j_q <= i_q + CW'(1); state_q <= S_PJ;
          end
        end
        S_PJ: begin
          if (j_q == i_q + CW'(1)) ci_q <= rd_q.c;
          else ci_q <= ci_q;
          state_q <= S_PWAIT;
        end
        S_PWAIT: if (rsp.done) begin
          if (rsp.hit) sup_q[j_q[AW-1:0]] <= 1'b1;
          if (j_q + CW'(1) >= cnt_q) begin
            i_q <= i_q + CW'(1); state_q <= S_PI;
          end else begin
            j_q <= j_q + CW'(1); state_q <= S_PJ;
          end
        end
        // output: find survivors in store order
        S_ORD: begin
          if (i_q == '0) last_keep_q <= last_keep_d;
          if (i_q >= cnt_q) state_q <= S_DONE;
          else if (sup_q[i_q[AW-1:0]]) i_q <= i_q + CW'(1);
          else state_q <= S_OWAIT;
        end
        S_OWAIT: begin
          kept_class_o <= rd_q.cls; kept_confidence_o <= rd_q.score;
          kept_left_o <= rd_q.c.left; kept_top_o <= rd_q.c.top;
          kept_right_o <= rd_q.c.right; kept_bottom_o <= rd_q.c.bottom;
          last_result_o <= (i_q == last_keep_q);
          overflowed_o <= ovf_q;
          out_valid_o <= 1'b1;
          state_q <= S_OSHOW;
        end
        S_OSHOW: if (!out_stall_i) begin
          out_valid_o <= 1'b0;
          i_q <= i_q + CW'(1);
          state_q <= last_result_o ? S_DONE : S_ORD;
        end
        S_DONE: begin
          cnt_q <= '0; ovf_q <= 1'b0; sup_q <= '0; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BNMS_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= CW'(MAX_BOXES), "box count past capacity")
  `BNMS_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q != S_IDLE) |-> in_stall_o, "input taken while busy")
  `BNMS_ASSERT(a_out_state, clk_i, rst_ni, out_valid_o |-> (state_q == S_OSHOW), "output beat outside show")
  `BNMS_ASSERT_NEVER(a_top_sup, clk_i, rst_ni, sup_q[0], "highest box suppressed")
endmodule
